// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property checked on every clock edge outside reset.
`define PSES_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Property checked on every clock edge, reset included.
`define PSES_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PSES_ASSERT(lbl, clk, rst, prop, msg)
`define PSES_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

// File: sv/pses_pkg.sv
`default_nettype none

package pses_pkg;

  localparam int WORD_W = 32;
  localparam int CNT_W  = $clog2(WORD_W);

  // Token queue between front and back.
  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW    = $clog2(FQ_DEPTH);
  localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

  // ASCII codes.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNDER   = 3'd1,
    ST_OVER    = 3'd2,
    ST_BADCHAR = 3'd3,
    ST_DIVZERO = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    K_DIGIT,
    K_SPACE,
    K_ADD,
    K_SUB,
    K_MUL,
    K_DIV,
    K_BAD
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] digit;
    logic       last;
  } item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_OP,
    BK_DIV,
    BK_EMIT
  } bk_state_t;

endpackage

`default_nettype wire

// File: sv/prefix_expression_stack_evaluator.sv
// Prefix expression evaluator with an operand stack.
// Input channel (in_valid/in_ready): one ASCII character per beat, sent right
// to left; last marks the leftmost character. Digits push, spaces are skipped,
// + - * / pop a (top) then b and push a op b in 32-bit wrapping arithmetic.
// Output channel (out_valid/out_ready): one beat per expression, carrying the
// final value and a status (0 ok, 1 underflow, 2 overflow, 3 bad character,
// 4 divide by zero); value reads 0 whenever status is nonzero.
// A four-entry token queue separates the classifier from the execute engine.
// Execute steps per character: a digit or space finishes when it is taken
// from the queue; + - or * pops a and b, then writes a op b back; / pops,
// starts the divider, waits while it forms the quotient, then writes back;
// the final character is followed by a step that loads the result. The
// engine works on one character at a time, and / is its slowest step.
// Reset (rst, synchronous) empties the stack, the queue and the error status.
// If the receiver stalls, the result is held; the engine keeps working on the
// next expression until it has another result to load, and the input side
// stalls only when the queue is full.
`default_nettype none

module prefix_expression_stack_evaluator #(
  parameter int STACK_DEPTH = 128
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    token,
  input  wire logic                          last,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [pses_pkg::WORD_W-1:0] value,
  output logic [2:0]                         status
);
  import pses_pkg::*;

  item_t item;
  logic  item_valid;
  logic  item_pop;

  // Front: classify and queue characters.
  pses_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .token      (token),
    .last       (last),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop)
  );

  // Back: stack, arithmetic and the result register.
  pses_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .status     (status)
  );

endmodule

`default_nettype wire

// File: sv/pses_front.sv
`default_nettype none
`include "assert_macros.svh"

module pses_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [7:0]     token,
  input  wire logic           last,
  output pses_pkg::item_t     item,
  output logic                item_valid,
  input  wire logic           item_pop
);
  import pses_pkg::*;

  item_t             fq [FQ_DEPTH];
  logic [FQ_AW-1:0]  wr_ptr;
  logic [FQ_AW-1:0]  rd_ptr;
  logic [FQ_CW-1:0]  count;
  item_t             cls;
  logic              push;
  logic              pop;

  // Classify the character.
  always_comb begin
    cls.digit = 4'(token - CH_ZERO);
    cls.last  = last;
    if (token >= CH_ZERO && token <= CH_NINE) begin
      cls.kind = K_DIGIT;
    end else begin
      unique case (token)
        CH_SPACE: cls.kind = K_SPACE;
        CH_PLUS:  cls.kind = K_ADD;
        CH_MINUS: cls.kind = K_SUB;
        CH_STAR:  cls.kind = K_MUL;
        CH_SLASH: cls.kind = K_DIV;
        default:  cls.kind = K_BAD;
      endcase
    end
  end

  assign in_ready   = (count != FQ_CW'(FQ_DEPTH));
  assign push       = in_valid && in_ready;
  assign item_valid = (count != '0);
  assign pop        = item_pop && item_valid;
  assign item       = fq[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fq[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FQ_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FQ_AW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + FQ_CW'(1);
        2'b01:   count <= count - FQ_CW'(1);
        default: count <= count;
      endcase
    end
  end

  `PSES_ASSERT(a_pop_only_nonempty, clk, rst, item_pop |-> count != '0, "pop from empty queue")
  `PSES_ASSERT(a_count_tracks, clk, rst, (push && !pop) |=> count == $past(count) + FQ_CW'(1), "queue count lost a push")
  `PSES_ASSERT(a_count_bound, clk, rst, count <= FQ_CW'(FQ_DEPTH), "queue count past depth")

endmodule

`default_nettype wire

// File: sv/pses_div.sv
`default_nettype none

module pses_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [pses_pkg::WORD_W-1:0] dividend,
  input  wire logic [pses_pkg::WORD_W-1:0] divisor,
  output logic                             busy,
  output logic                             done,
  output logic [pses_pkg::WORD_W-1:0]      quotient
);
  import pses_pkg::*;

  logic [CNT_W-1:0]  cnt;
  logic              neg;
  logic [WORD_W-1:0] ub;
  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] dq;
  logic [WORD_W:0]   rem_sh;
  logic              fits;

  // Restoring division on magnitudes, one quotient bit per cycle.
  assign rem_sh   = {rem, dq[WORD_W-1]};
  assign fits     = (rem_sh >= {1'b0, ub});
  assign quotient = neg ? (WORD_W'(0) - dq) : dq;

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
      dq  <= dividend[WORD_W-1] ? (WORD_W'(0) - dividend) : dividend;
      ub  <= divisor[WORD_W-1] ? (WORD_W'(0) - divisor) : divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? WORD_W'(rem_sh - {1'b0, ub}) : rem_sh[WORD_W-1:0];
      dq  <= {dq[WORD_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(WORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/pses_back.sv
`default_nettype none
`include "assert_macros.svh"

module pses_back #(
  parameter int STACK_DEPTH = 128
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire pses_pkg::item_t                    item,
  input  wire logic                               item_valid,
  output logic                                    item_pop,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [pses_pkg::WORD_W-1:0]      value,
  output logic [2:0]                              status
);
  import pses_pkg::*;

  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int DW     = $clog2(STACK_DEPTH + 1);

  bk_state_t         state;
  bk_state_t         state_next;
  logic [DW-1:0]     depth;
  logic [DW-1:0]     depth_next;
  status_t           err;
  status_t           err_next;
  logic [WORD_W-1:0] tos;
  logic [WORD_W-1:0] tos_next;
  item_t             cur;
  item_t             cur_next;

  logic [WORD_W-1:0] mem [STACK_DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [WORD_W-1:0] rdata;

  logic [DW-1:0]     depth_m1;
  logic [DW-1:0]     depth_m2;
  logic              tok_done;
  logic              out_load;
  logic              div_start;
  logic              div_busy;
  logic              div_done;
  logic [WORD_W-1:0] div_q;

  // Top of stack lives in tos; entries below it live in mem.
  assign depth_m1  = depth - DW'(1);
  assign depth_m2  = depth - DW'(2);
  assign mem_raddr = depth_m2[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  pses_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (tos),
    .divisor  (rdata),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_next = state;
    depth_next = depth;
    err_next   = err;
    tos_next   = tos;
    cur_next   = cur;
    item_pop   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = depth_m1[ADDR_W-1:0];
    mem_wdata  = tos;
    div_start  = 1'b0;
    out_load   = 1'b0;
    tok_done   = 1'b0;

    unique case (state)
      BK_IDLE: begin
        if (item_valid) begin
          item_pop = 1'b1;
          cur_next = item;
          if (err != ST_OK) begin
            tok_done = 1'b1;
          end else begin
            unique case (item.kind)
              K_DIGIT: begin
                tok_done = 1'b1;
                if (depth == DW'(STACK_DEPTH)) begin
                  err_next = ST_OVER;
                end else begin
                  mem_we     = (depth != '0);
                  tos_next   = WORD_W'(item.digit);
                  depth_next = depth + DW'(1);
                end
              end
              K_SPACE: tok_done = 1'b1;
              default: begin
                priority if (depth < DW'(2)) begin
                  err_next = ST_UNDER;
                  tok_done = 1'b1;
                end else if (item.kind == K_BAD) begin
                  err_next = ST_BADCHAR;
                  tok_done = 1'b1;
                end else begin
                  state_next = BK_OP;
                end
              end
            endcase
          end
        end
      end
      BK_OP: begin
        unique case (cur.kind)
          K_ADD: begin
            tos_next   = tos + rdata;
            depth_next = depth_m1;
            tok_done   = 1'b1;
          end
          K_SUB: begin
            tos_next   = tos - rdata;
            depth_next = depth_m1;
            tok_done   = 1'b1;
          end
          K_MUL: begin
            tos_next   = tos * rdata;
            depth_next = depth_m1;
            tok_done   = 1'b1;
          end
          K_DIV: begin
            if (rdata == '0) begin
              err_next = ST_DIVZERO;
              tok_done = 1'b1;
            end else begin
              div_start  = 1'b1;
              state_next = BK_DIV;
            end
          end
          default: tok_done = 1'b1;
        endcase
      end
      BK_DIV: begin
        if (div_done) begin
          tos_next   = div_q;
          depth_next = depth_m1;
          tok_done   = 1'b1;
        end
      end
      BK_EMIT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          depth_next = '0;
          err_next   = ST_OK;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase

    if (tok_done) begin
      state_next = cur_next.last ? BK_EMIT : BK_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      depth <= '0;
      err   <= ST_OK;
    end else begin
      state <= state_next;
      depth <= depth_next;
      err   <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    tos <= tos_next;
    cur <= cur_next;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      priority if (err != ST_OK) begin
        value  <= '0;
        status <= err;
      end else if (depth == '0) begin
        value  <= '0;
        status <= ST_UNDER;
      end else begin
        value  <= tos;
        status <= ST_OK;
      end
    end
  end

  `PSES_ASSERT_RST(a_rst_empties, clk, rst |=> depth == '0 && err == ST_OK, "reset left stack state")
  `PSES_ASSERT(a_depth_bound, clk, rst, depth <= DW'(STACK_DEPTH), "stack depth past capacity")
  `PSES_ASSERT(a_err_value_zero, clk, rst, (out_valid && status != ST_OK) |-> value == '0, "error result with nonzero value")
  `PSES_ASSERT(a_emit_clears, clk, rst, out_load |=> depth == '0 && err == ST_OK && out_valid, "emit did not clear stack")
  `PSES_ASSERT(a_div_owned, clk, rst, div_busy |-> state == BK_DIV, "divider running outside divide state")

endmodule

`default_nettype wire
